### rtl/masked_byte_pattern_search_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the masked byte pattern search
// Concurrent assertion wrappers that can be compiled out with ASSERT_OFF.
// ---------------------------------------------------------------------------
`ifndef MASKED_BYTE_PATTERN_SEARCH_ASSERT_SVH
`define MASKED_BYTE_PATTERN_SEARCH_ASSERT_SVH

`ifndef ASSERT_OFF

// Property must hold at every rising edge outside reset.
`define MBPS_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("masked byte pattern search: assertion failed");

// Condition must never be seen at a rising edge outside reset.
`define MBPS_ASSERT_NEVER(name, clk, rst, cond) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("masked byte pattern search: forbidden condition seen");

`else

`define MBPS_ASSERT(name, clk, rst, prop)
`define MBPS_ASSERT_NEVER(name, clk, rst, cond)

`endif

`endif

### rtl/mbps_pkg.sv
// ---------------------------------------------------------------------------
// Masked byte pattern search package
// Sizes, register indexes and the types shared between the pipeline stages.
// ---------------------------------------------------------------------------
package mbps_pkg;

  localparam int PATTERN_MAX   = 16;
  localparam int POSITION_BITS = 32;
  localparam int PATTERN_HW    = 16;
  localparam int ADDR_BITS     = 64;
  localparam int LEN_BITS      = 5;
  localparam int SKIP_BITS     = 4;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 64;

  // Window positions that can take part in a compare.
  localparam int CMP_MAX      = (PATTERN_MAX < PATTERN_HW) ? PATTERN_MAX : PATTERN_HW;
  localparam int FILL_BITS    = $clog2(CMP_MAX + 1);
  localparam int WIN_IDX_BITS = (CMP_MAX > 1) ? $clog2(CMP_MAX) : 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_LOW  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_HIGH = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_CARE_MASK    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_LENGTH       = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_FIND_ALL     = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_BASE         = 3'd5;

  typedef struct packed {
    logic [PATTERN_HW*8-1:0] pattern;
    logic [PATTERN_HW-1:0]   care_mask;
    logic [LEN_BITS-1:0]     pattern_length;
    logic                    find_all;
    logic [ADDR_BITS-1:0]    base_address;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       region_end;
  } item_t;

  typedef struct packed {
    logic                     found;
    logic [POSITION_BITS-1:0] offset;
    logic                     region_done;
  } scan_result_t;

endpackage

### rtl/mbps_match.sv
// ---------------------------------------------------------------------------
// Masked pattern comparator
// Compares the window ending at the newest byte with the configured pattern.
// ---------------------------------------------------------------------------
module mbps_match (
  input  logic [7:0]     win [mbps_pkg::CMP_MAX],
  input  mbps_pkg::cfg_t cfg,
  output logic           hit
);

  logic [mbps_pkg::CMP_MAX-1:0] byte_ok;
  logic                         len_ok;

  // Pattern byte k lines up with window entry length-1-k.
  for (genvar k = 0; k < mbps_pkg::CMP_MAX; k++) begin : g_cmp
    logic [mbps_pkg::LEN_BITS-1:0] idx;
    logic                          active;

    assign active = mbps_pkg::LEN_BITS'(k) < cfg.pattern_length;
    assign idx    = cfg.pattern_length - mbps_pkg::LEN_BITS'(k) - mbps_pkg::LEN_BITS'(1);
    assign byte_ok[k] = !active || !cfg.care_mask[k] ||
                        (win[idx[mbps_pkg::WIN_IDX_BITS-1:0]] == cfg.pattern[k*8 +: 8]);
  end

  assign len_ok = (cfg.pattern_length != '0) &&
                  (cfg.pattern_length <= mbps_pkg::LEN_BITS'(mbps_pkg::CMP_MAX));
  assign hit    = len_ok && (&byte_ok);

endmodule

### rtl/mbps_scan.sv
// ---------------------------------------------------------------------------
// Scan stage
// Holds the byte window and region state and decides what each byte reports.
// ---------------------------------------------------------------------------
`include "masked_byte_pattern_search_assert.svh"

module mbps_scan (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  logic                   in_valid,
  input  mbps_pkg::item_t        in_item,
  input  mbps_pkg::cfg_t         cfg,
  output logic                   res_valid,
  output mbps_pkg::scan_result_t res
);

  logic [7:0]                         window [mbps_pkg::CMP_MAX];
  logic [7:0]                         window_next [mbps_pkg::CMP_MAX];
  logic [mbps_pkg::FILL_BITS-1:0]     fill_count;
  logic [mbps_pkg::FILL_BITS-1:0]     fill_count_next;
  logic [mbps_pkg::POSITION_BITS-1:0] byte_position;
  logic [mbps_pkg::SKIP_BITS-1:0]     skip_left;
  logic [mbps_pkg::SKIP_BITS-1:0]     skip_left_next;
  logic                               first_found;
  logic                               first_found_next;
  logic                               pattern_hit;
  logic                               hit;
  logic                               skipping;
  logic                               report;
  logic [mbps_pkg::POSITION_BITS-1:0] start;
  logic [mbps_pkg::LEN_BITS-1:0]      len_less_one;
  logic                               take;

  assign take = advance && in_valid;

  always_comb begin
    window_next[0] = in_item.data_byte;
    for (int i = 1; i < mbps_pkg::CMP_MAX; i++) begin
      window_next[i] = window[i-1];
    end
  end

  assign fill_count_next = (fill_count < mbps_pkg::FILL_BITS'(mbps_pkg::CMP_MAX))
                           ? fill_count + mbps_pkg::FILL_BITS'(1) : fill_count;

  mbps_match u_match (
    .win (window_next),
    .cfg (cfg),
    .hit (pattern_hit)
  );

  assign hit          = pattern_hit &&
                        (mbps_pkg::LEN_BITS'(fill_count_next) >= cfg.pattern_length);
  assign skipping     = cfg.find_all && (skip_left != '0);
  assign report       = !skipping && hit && (cfg.find_all || !first_found);
  assign len_less_one = cfg.pattern_length - mbps_pkg::LEN_BITS'(1);
  assign start        = byte_position - mbps_pkg::POSITION_BITS'(len_less_one);

  always_comb begin
    skip_left_next   = skip_left;
    first_found_next = first_found;
    if (skipping) begin
      skip_left_next = skip_left - mbps_pkg::SKIP_BITS'(1);
    end else if (hit && cfg.find_all) begin
      skip_left_next = len_less_one[mbps_pkg::SKIP_BITS-1:0];
    end else if (hit) begin
      first_found_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      window <= window_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count    <= '0;
      byte_position <= '0;
      skip_left     <= '0;
      first_found   <= 1'b0;
      res_valid     <= 1'b0;
    end else if (advance) begin
      res_valid <= in_valid && (report || in_item.region_end);
      if (in_valid) begin
        if (in_item.region_end) begin
          fill_count    <= '0;
          byte_position <= '0;
          skip_left     <= '0;
          first_found   <= 1'b0;
        end else begin
          fill_count    <= fill_count_next;
          byte_position <= byte_position + mbps_pkg::POSITION_BITS'(1);
          skip_left     <= skip_left_next;
          first_found   <= first_found_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res.found       <= report;
      res.offset      <= start;
      res.region_done <= in_item.region_end;
    end
  end

  `MBPS_ASSERT(a_fill_bounded, clk, rst, fill_count <= mbps_pkg::FILL_BITS'(mbps_pkg::CMP_MAX))
  `MBPS_ASSERT(a_region_end_clears, clk, rst, (take && in_item.region_end) |=> (fill_count == '0 && skip_left == '0 && !first_found && byte_position == '0))

endmodule

### rtl/mbps_out.sv
// ---------------------------------------------------------------------------
// Output stage
// Forms the match address from the base address and holds the result item.
// ---------------------------------------------------------------------------
module mbps_out (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           advance,
  input  logic                           res_valid,
  input  mbps_pkg::scan_result_t         res,
  input  logic [mbps_pkg::ADDR_BITS-1:0] base_address,
  output logic                           out_valid,
  output logic                           found,
  output logic [mbps_pkg::ADDR_BITS-1:0] match_address,
  output logic                           region_done
);

  logic [mbps_pkg::ADDR_BITS-1:0] address_next;

  assign address_next = res.found
                        ? base_address + mbps_pkg::ADDR_BITS'(res.offset)
                        : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      found         <= res.found;
      match_address <= address_next;
      region_done   <= res.region_done;
    end
  end

endmodule

### rtl/masked_byte_pattern_search.sv
// ---------------------------------------------------------------------------
// Masked byte pattern search
// Streams a memory region one byte per item and reports masked pattern hits.
// ---------------------------------------------------------------------------
// The block accepts one byte every clock cycle unless stalled, and passes
// each byte through three register stages: an input register, a scan stage
// in which the window of the last sixteen bytes is compared with the pattern,
// and an output register in which the 64-bit match address is formed. All
// three stages move together, so the input is stalled only while a result
// waits at the output for the consumer. A byte produces a result item only
// when it completes a reported match or ends the region; the final byte always
// produces one, with the found flag clear when there was no match on it.
// Configuration should be written while the block is idle, and it takes
// effect for the next byte taken.
// ---------------------------------------------------------------------------
`include "masked_byte_pattern_search_assert.svh"

module masked_byte_pattern_search (
  input  logic                               clk,
  input  logic                               rst,
  // Configuration write channel.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mbps_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [mbps_pkg::CFG_DATA_BITS-1:0] cfg_data,
  // Byte stream in.
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [7:0]                         s_tdata,   // data_byte
  input  logic                               s_tlast,   // region_end
  // Result stream out.
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [mbps_pkg::ADDR_BITS-1:0]     m_tdata,   // match_address
  output logic                               m_tuser,   // found
  output logic                               m_tlast    // region_done
);

  mbps_pkg::cfg_t         cfg;
  mbps_pkg::item_t        in_item;
  logic                   in_valid;
  logic                   advance;
  logic                   res_valid;
  mbps_pkg::scan_result_t res;

  // Configuration registers are always ready to be written.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern        <= '0;
      cfg.care_mask      <= '1;
      cfg.pattern_length <= '0;
      cfg.find_all       <= 1'b0;
      cfg.base_address   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mbps_pkg::REG_PATTERN_LOW: begin
          cfg.pattern[63:0] <= cfg_data;
        end
        mbps_pkg::REG_PATTERN_HIGH: begin
          cfg.pattern[127:64] <= cfg_data;
        end
        mbps_pkg::REG_CARE_MASK: begin
          cfg.care_mask <= cfg_data[mbps_pkg::PATTERN_HW-1:0];
        end
        mbps_pkg::REG_LENGTH: begin
          cfg.pattern_length <= cfg_data[mbps_pkg::LEN_BITS-1:0];
        end
        mbps_pkg::REG_FIND_ALL: begin
          cfg.find_all <= cfg_data[0];
        end
        mbps_pkg::REG_BASE: begin
          cfg.base_address <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  // The whole pipeline moves whenever the output register is free or being
  // emptied in this cycle.
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (advance) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s_tvalid) begin
      in_item.data_byte  <= s_tdata;
      in_item.region_end <= s_tlast;
    end
  end

  mbps_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  mbps_out u_out (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .res_valid     (res_valid),
    .res           (res),
    .base_address  (cfg.base_address),
    .out_valid     (m_tvalid),
    .found         (m_tuser),
    .match_address (m_tdata),
    .region_done   (m_tlast)
  );

  // A result without a match can only be the end of a region.
  `MBPS_ASSERT(a_nomatch_is_done, clk, rst, (m_tvalid && !m_tuser) |-> (m_tlast && m_tdata == '0))
  // Input back-pressure only comes from a waiting result.
  `MBPS_ASSERT_NEVER(a_stall_needs_cause, clk, rst, !s_tready && !(m_tvalid && !m_tready))

endmodule
